// File: sv/point_cloud_ray_pick_defines.svh
// assertion macros shared by the point cloud ray pick block
`ifndef POINT_CLOUD_RAY_PICK_DEFINES_SVH
`define POINT_CLOUD_RAY_PICK_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define PCRP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define PCRP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/pcrp_pkg.sv
package pcrp_pkg;

  // func codes of an input beat
  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_PICK  = 2'd1;
  localparam logic [1:0] FUNC_NEAR  = 2'd2;
  localparam logic [1:0] FUNC_CLEAR = 2'd3;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TANGENT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIST_WEIGHT = 1'd1;

  // datapath widths
  localparam int CNT_W   = 11;   // point count
  localparam int T_W     = 50;   // signed ray depth, Q(F+14)
  localparam int TT_W    = 35;   // ray depth t, Q.F
  localparam int Q_W     = 52;   // signed perpendicular component
  localparam int QM_W    = 51;   // its magnitude
  localparam int PERP_W  = 106;  // 16 * |P|^2
  localparam int TSQ_W   = 70;   // t squared
  localparam int REM_W   = 71;   // divider remainder
  localparam int TAN_W   = 48;   // tan2 of a qualifying point
  localparam int S_W     = 60;   // score factor
  localparam int SCORE_W = 108;  // score or squared distance
  localparam int SQX_W   = 66;   // square root operand
  localparam int RES_W   = 34;   // square root result
  localparam int MUL_W   = 64;   // multiplier operand

  typedef struct packed {
    logic [1:0]         func;
    logic [9:0]         point_index;
    logic               last_point;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
  } in_beat_t;

  typedef struct packed {
    logic        found;
    logic [9:0]  best_index;
    logic [31:0] measure;
  } out_beat_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_VEC, ST_MUL, ST_TCHK, ST_DCHK, ST_DIV, ST_LCHK, ST_CMP, ST_DONE
  } state_t;

  // which product the shared multiplier is working on
  typedef enum logic [3:0] {
    MOP_VDX, MOP_VDY, MOP_VDZ, MOP_DTX, MOP_QQX, MOP_DTY, MOP_QQY, MOP_DTZ,
    MOP_QQZ, MOP_TT, MOP_TW, MOP_SCORE, MOP_NX, MOP_NY, MOP_NZ, MOP_SQ
  } mop_t;

  typedef struct packed {
    logic             go;
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic [2*MUL_W-1:0] prod;
  } mul_rsp_t;

endpackage

// File: sv/pcrp_ram.sv
module pcrp_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 1024
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/pcrp_mul.sv
module pcrp_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  pcrp_pkg::mul_req_t req,
  output pcrp_pkg::mul_rsp_t rsp
);

  logic [pcrp_pkg::MUL_W-1:0]   a_r;
  logic [pcrp_pkg::MUL_W-1:0]   b_r;
  logic [2:0]                   step_r;
  logic                         busy_r;
  logic [63:0]                  pp_r;
  logic [1:0]                   pp_sh_r;
  logic                         pp_vld_r;
  logic [2*pcrp_pkg::MUL_W-1:0] acc_r;
  logic                         done_r;
  logic [31:0]                  a_limb;
  logic [31:0]                  b_limb;
  logic [1:0]                   sh;
  logic [63:0]                  pp_calc;
  logic [2*pcrp_pkg::MUL_W-1:0] pp_ext;

  // pick the 32-bit limbs for this step
  always_comb begin
    a_limb  = step_r[1] ? a_r[63:32] : a_r[31:0];
    b_limb  = step_r[0] ? b_r[63:32] : b_r[31:0];
    sh      = {1'b0, step_r[1]} + {1'b0, step_r[0]};
    pp_calc = a_limb * b_limb;
  end

  // align the partial product
  always_comb begin
    unique case (pp_sh_r)
      2'd0:    pp_ext = {64'd0, pp_r};
      2'd1:    pp_ext = {32'd0, pp_r, 32'd0};
      2'd2:    pp_ext = {pp_r, 64'd0};
      default: pp_ext = '0;
    endcase
  end

  // four partial products, each accumulated in the cycle after it is formed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      done_r   <= 1'b0;
      pp_vld_r <= 1'b0;
      step_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        a_r      <= req.a;
        b_r      <= req.b;
        acc_r    <= '0;
        step_r   <= '0;
        busy_r   <= 1'b1;
        pp_vld_r <= 1'b0;
      end else if (busy_r) begin
        if (step_r != 3'd4) begin
          pp_r     <= pp_calc;
          pp_sh_r  <= sh;
          pp_vld_r <= 1'b1;
          step_r   <= step_r + 3'd1;
        end else begin
          pp_vld_r <= 1'b0;
        end
        if (pp_vld_r) begin
          acc_r <= acc_r + pp_ext;
        end
        if (step_r == 3'd4 && pp_vld_r) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

endmodule

// File: sv/point_cloud_ray_pick.sv
// load and clear take effect in the cycle they are accepted, no result beat
// a query scans the stored points one at a time through a shared 4-step multiplier,
// then takes the square root of the winning measure
// a query blocks the input until its result sits in the output register
// synchronous active-low reset clears count, state and config; the point store is not cleared
`include "point_cloud_ray_pick_defines.svh"

module point_cloud_ray_pick #(
  parameter int MAX_POINTS      = 1024,
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  pcrp_pkg::in_beat_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output pcrp_pkg::out_beat_t                 out_data,
  input  logic                                cfg_we,
  input  logic [pcrp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pcrp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam logic signed [pcrp_pkg::T_W-1:0] PICK_EPS =
    pcrp_pkg::T_W'((64'd1 << (COORD_FRAC_BITS + 14)) / 64'd10000);
  localparam logic [pcrp_pkg::S_W-1:0] SCORE_ONE =
    pcrp_pkg::S_W'(64'd1 << (COORD_FRAC_BITS + 16));

  pcrp_pkg::state_t state_r, state_nxt;
  pcrp_pkg::mop_t   mop_r;
  pcrp_pkg::in_beat_t qry_r;
  pcrp_pkg::out_beat_t out_data_r;
  pcrp_pkg::mul_req_t mul_req;
  pcrp_pkg::mul_rsp_t mul_rsp;

  logic                               out_valid_r;
  logic                               mul_pend_r;
  logic [pcrp_pkg::CNT_W-1:0]         count_r;
  logic [pcrp_pkg::CNT_W-1:0]         scan_idx_r;
  logic [15:0]                        max_tangent_r;
  logic [23:0]                        weight_r;
  logic [31:0]                        mt_sq;
  logic [pcrp_pkg::TAN_W-1:0]         limit_r;
  logic signed [32:0]                 vx_r, vy_r, vz_r;
  logic signed [pcrp_pkg::T_W-1:0]    t_acc_r;
  logic [pcrp_pkg::TT_W-1:0]          t_r;
  logic [pcrp_pkg::QM_W-1:0]          qmag_r;
  logic [pcrp_pkg::PERP_W-1:0]        perp_r;
  logic [pcrp_pkg::TSQ_W-1:0]         tsq_r;
  logic [pcrp_pkg::REM_W-1:0]         rem_r;
  logic [5:0]                         div_cnt_r;
  logic [pcrp_pkg::TAN_W-1:0]         tan2_r;
  logic [pcrp_pkg::S_W-1:0]           s_r;
  logic [pcrp_pkg::SCORE_W-1:0]       cand_r;
  logic                               found_r;
  logic [pcrp_pkg::SCORE_W-1:0]       best_val_r;
  logic [pcrp_pkg::CNT_W-1:0]         best_idx_r;
  logic [pcrp_pkg::TAN_W-1:0]         best_tan2_r;
  logic [pcrp_pkg::SQX_W-1:0]         sq_x_r;
  logic [pcrp_pkg::RES_W-1:0]         sq_res_r;
  logic [5:0]                         sq_bit_r;

  logic                               is_query;
  logic                               ram_we;
  logic [AW-1:0]                      ram_raddr;
  logic [95:0]                        ram_rdata;
  logic signed [32:0]                 v_sel;
  logic signed [15:0]                 d_sel;
  logic [32:0]                        v_mag;
  logic signed [16:0]                 d_ext;
  logic [16:0]                        d_mag;
  logic signed [pcrp_pkg::T_W-1:0]    vd_prod;
  logic signed [pcrp_pkg::T_W-1:0]    vd_term;
  logic signed [pcrp_pkg::Q_W-1:0]    dt_prod;
  logic signed [pcrp_pkg::Q_W-1:0]    dt_term;
  logic signed [pcrp_pkg::Q_W-1:0]    v_sh;
  logic signed [pcrp_pkg::Q_W-1:0]    q_val;
  logic [pcrp_pkg::QM_W-1:0]          q_mag;
  logic [pcrp_pkg::PERP_W-1:0]        perp16;
  logic [pcrp_pkg::TAN_W-1:0]         div_low;
  logic [pcrp_pkg::REM_W-1:0]         div_r2;
  logic [pcrp_pkg::RES_W-1:0]         sq_cand;
  logic                               t_skip;
  logic                               d_skip;
  logic                               better;

  // point store
  pcrp_ram #(
    .WIDTH(96),
    .DEPTH(MAX_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_data.point_index)),
    .wdata ({in_data.pos_x, in_data.pos_y, in_data.pos_z}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shared multiplier
  pcrp_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  // axis operands for the current product
  always_comb begin
    unique case (mop_r)
      pcrp_pkg::MOP_VDY, pcrp_pkg::MOP_DTY, pcrp_pkg::MOP_QQY, pcrp_pkg::MOP_NY: begin
        v_sel = vy_r;
        d_sel = qry_r.dir_y;
      end
      pcrp_pkg::MOP_VDZ, pcrp_pkg::MOP_DTZ, pcrp_pkg::MOP_QQZ, pcrp_pkg::MOP_NZ: begin
        v_sel = vz_r;
        d_sel = qry_r.dir_z;
      end
      default: begin
        v_sel = vx_r;
        d_sel = qry_r.dir_x;
      end
    endcase
    v_mag   = v_sel[32] ? 33'(-v_sel) : 33'(v_sel);
    d_ext   = {d_sel[15], d_sel};
    d_mag   = d_ext[16] ? 17'(-d_ext) : 17'(d_ext);
    vd_prod = $signed(pcrp_pkg::T_W'(mul_rsp.prod));
    vd_term = (v_sel[32] ^ d_sel[15]) ? -vd_prod : vd_prod;
    dt_prod = $signed(pcrp_pkg::Q_W'(mul_rsp.prod));
    dt_term = d_sel[15] ? -dt_prod : dt_prod;
    v_sh    = {{(pcrp_pkg::Q_W - 47){v_sel[32]}}, v_sel, 14'd0};
    q_val   = v_sh - dt_term;
    q_mag   = q_val[pcrp_pkg::Q_W-1] ? pcrp_pkg::QM_W'(-q_val) : pcrp_pkg::QM_W'(q_val);
  end

  // divide, skip tests and root candidate
  always_comb begin
    perp16  = {perp_r[pcrp_pkg::PERP_W-5:0], 4'd0};
    div_low = perp16[pcrp_pkg::TAN_W-1:0];
    div_r2  = {rem_r[pcrp_pkg::REM_W-2:0], div_low[div_cnt_r]};
    t_skip  = (t_acc_r <= PICK_EPS) || (t_acc_r[pcrp_pkg::TT_W+13:14] == '0);
    d_skip  = {12'd0, perp16} >= {tsq_r, 48'd0};
    better  = !found_r || (cand_r < best_val_r);
    sq_cand = sq_res_r | (pcrp_pkg::RES_W'(1) << sq_bit_r);
    mt_sq   = 32'(max_tangent_r) * 32'(max_tangent_r);
    is_query = (in_data.func == pcrp_pkg::FUNC_PICK) || (in_data.func == pcrp_pkg::FUNC_NEAR);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pcrp_pkg::ST_IDLE: begin
        if (in_valid && is_query) state_nxt = pcrp_pkg::ST_SCAN;
      end
      pcrp_pkg::ST_SCAN: begin
        if (scan_idx_r < count_r) state_nxt = pcrp_pkg::ST_VEC;
        else if (found_r)         state_nxt = pcrp_pkg::ST_MUL;
        else                      state_nxt = pcrp_pkg::ST_DONE;
      end
      pcrp_pkg::ST_VEC: state_nxt = pcrp_pkg::ST_MUL;
      pcrp_pkg::ST_MUL: begin
        if (mul_rsp.done) begin
          unique case (mop_r)
            pcrp_pkg::MOP_VDZ:   state_nxt = pcrp_pkg::ST_TCHK;
            pcrp_pkg::MOP_TT:    state_nxt = pcrp_pkg::ST_DCHK;
            pcrp_pkg::MOP_SCORE: state_nxt = pcrp_pkg::ST_CMP;
            pcrp_pkg::MOP_NZ:    state_nxt = pcrp_pkg::ST_CMP;
            pcrp_pkg::MOP_SQ: begin
              if (sq_bit_r == '0) state_nxt = pcrp_pkg::ST_DONE;
            end
            default: state_nxt = pcrp_pkg::ST_MUL;
          endcase
        end
      end
      pcrp_pkg::ST_TCHK: state_nxt = t_skip ? pcrp_pkg::ST_SCAN : pcrp_pkg::ST_MUL;
      pcrp_pkg::ST_DCHK: state_nxt = d_skip ? pcrp_pkg::ST_SCAN : pcrp_pkg::ST_DIV;
      pcrp_pkg::ST_DIV: begin
        if (div_cnt_r == '0) state_nxt = pcrp_pkg::ST_LCHK;
      end
      pcrp_pkg::ST_LCHK: begin
        state_nxt = (tan2_r >= limit_r) ? pcrp_pkg::ST_SCAN : pcrp_pkg::ST_MUL;
      end
      pcrp_pkg::ST_CMP: state_nxt = pcrp_pkg::ST_SCAN;
      pcrp_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) state_nxt = pcrp_pkg::ST_IDLE;
      end
      default: state_nxt = pcrp_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall   = (state_r != pcrp_pkg::ST_IDLE);
    ram_we     = (state_r == pcrp_pkg::ST_IDLE) && in_valid &&
                 (in_data.func == pcrp_pkg::FUNC_LOAD) &&
                 (32'(in_data.point_index) < MAX_POINTS);
    ram_raddr  = AW'(scan_idx_r);
    mul_req.go = (state_r == pcrp_pkg::ST_MUL) && !mul_pend_r;
    unique case (mop_r)
      pcrp_pkg::MOP_VDX, pcrp_pkg::MOP_VDY, pcrp_pkg::MOP_VDZ: begin
        mul_req.a = 64'(v_mag);
        mul_req.b = 64'(d_mag);
      end
      pcrp_pkg::MOP_DTX, pcrp_pkg::MOP_DTY, pcrp_pkg::MOP_DTZ: begin
        mul_req.a = 64'(d_mag);
        mul_req.b = 64'(t_r);
      end
      pcrp_pkg::MOP_QQX, pcrp_pkg::MOP_QQY, pcrp_pkg::MOP_QQZ: begin
        mul_req.a = 64'(qmag_r);
        mul_req.b = 64'(qmag_r);
      end
      pcrp_pkg::MOP_TT: begin
        mul_req.a = 64'(t_r);
        mul_req.b = 64'(t_r);
      end
      pcrp_pkg::MOP_TW: begin
        mul_req.a = 64'(t_r);
        mul_req.b = 64'(weight_r);
      end
      pcrp_pkg::MOP_SCORE: begin
        mul_req.a = 64'(tan2_r);
        mul_req.b = 64'(s_r);
      end
      pcrp_pkg::MOP_NX, pcrp_pkg::MOP_NY, pcrp_pkg::MOP_NZ: begin
        mul_req.a = 64'(v_mag);
        mul_req.b = 64'(v_mag);
      end
      pcrp_pkg::MOP_SQ: begin
        mul_req.a = 64'(sq_cand);
        mul_req.b = 64'(sq_cand);
      end
      default: begin
        mul_req.a = '0;
        mul_req.b = '0;
      end
    endcase
  end

  // control registers, config and store count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= pcrp_pkg::ST_IDLE;
      mop_r         <= pcrp_pkg::MOP_VDX;
      out_valid_r   <= 1'b0;
      mul_pend_r    <= 1'b0;
      count_r       <= '0;
      max_tangent_r <= 16'd256;
      weight_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          pcrp_pkg::CFG_MAX_TANGENT: max_tangent_r <= cfg_wdata[15:0];
          pcrp_pkg::CFG_DIST_WEIGHT: weight_r      <= cfg_wdata;
          default: ;
        endcase
      end
      if (ram_we && in_data.last_point) begin
        count_r <= pcrp_pkg::CNT_W'(in_data.point_index) + pcrp_pkg::CNT_W'(1);
      end
      if (state_r == pcrp_pkg::ST_IDLE && in_valid && in_data.func == pcrp_pkg::FUNC_CLEAR) begin
        count_r <= '0;
      end
      if (mul_req.go)        mul_pend_r <= 1'b1;
      else if (mul_rsp.done) mul_pend_r <= 1'b0;
      if (state_r == pcrp_pkg::ST_DONE && state_nxt == pcrp_pkg::ST_IDLE) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      // product sequence
      if (state_r == pcrp_pkg::ST_VEC) begin
        mop_r <= (qry_r.func == pcrp_pkg::FUNC_PICK) ? pcrp_pkg::MOP_VDX : pcrp_pkg::MOP_NX;
      end else if (state_r == pcrp_pkg::ST_SCAN && state_nxt == pcrp_pkg::ST_MUL) begin
        mop_r <= pcrp_pkg::MOP_SQ;
      end else if (state_r == pcrp_pkg::ST_TCHK) begin
        mop_r <= pcrp_pkg::MOP_DTX;
      end else if (state_r == pcrp_pkg::ST_LCHK) begin
        mop_r <= pcrp_pkg::MOP_TW;
      end else if (state_r == pcrp_pkg::ST_MUL && mul_rsp.done) begin
        unique case (mop_r)
          pcrp_pkg::MOP_VDX: mop_r <= pcrp_pkg::MOP_VDY;
          pcrp_pkg::MOP_VDY: mop_r <= pcrp_pkg::MOP_VDZ;
          pcrp_pkg::MOP_DTX: mop_r <= pcrp_pkg::MOP_QQX;
          pcrp_pkg::MOP_QQX: mop_r <= pcrp_pkg::MOP_DTY;
          pcrp_pkg::MOP_DTY: mop_r <= pcrp_pkg::MOP_QQY;
          pcrp_pkg::MOP_QQY: mop_r <= pcrp_pkg::MOP_DTZ;
          pcrp_pkg::MOP_DTZ: mop_r <= pcrp_pkg::MOP_QQZ;
          pcrp_pkg::MOP_QQZ: mop_r <= pcrp_pkg::MOP_TT;
          pcrp_pkg::MOP_TW:  mop_r <= pcrp_pkg::MOP_SCORE;
          pcrp_pkg::MOP_NX:  mop_r <= pcrp_pkg::MOP_NY;
          pcrp_pkg::MOP_NY:  mop_r <= pcrp_pkg::MOP_NZ;
          default: ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    limit_r <= {mt_sq, 16'd0};
    // query capture and scan pointer
    if (state_r == pcrp_pkg::ST_IDLE) begin
      qry_r <= in_data;
    end
    if (state_nxt == pcrp_pkg::ST_SCAN) begin
      if (state_r == pcrp_pkg::ST_IDLE) begin
        scan_idx_r <= '0;
        found_r    <= 1'b0;
      end else begin
        scan_idx_r <= scan_idx_r + pcrp_pkg::CNT_W'(1);
      end
    end
    // offset of the stored point from the query position
    if (state_r == pcrp_pkg::ST_VEC) begin
      vx_r <= $signed({ram_rdata[95], ram_rdata[95:64]}) - $signed({qry_r.pos_x[31], qry_r.pos_x});
      vy_r <= $signed({ram_rdata[63], ram_rdata[63:32]}) - $signed({qry_r.pos_y[31], qry_r.pos_y});
      vz_r <= $signed({ram_rdata[31], ram_rdata[31:0]}) - $signed({qry_r.pos_z[31], qry_r.pos_z});
    end
    // sqrt operand
    if (state_r == pcrp_pkg::ST_SCAN && state_nxt == pcrp_pkg::ST_MUL) begin
      sq_res_r <= '0;
      sq_bit_r <= 6'(pcrp_pkg::RES_W - 1);
      sq_x_r   <= (qry_r.func == pcrp_pkg::FUNC_PICK) ? pcrp_pkg::SQX_W'(best_tan2_r)
                                                      : pcrp_pkg::SQX_W'(best_val_r);
    end
    if (state_r == pcrp_pkg::ST_TCHK) begin
      t_r <= t_acc_r[pcrp_pkg::TT_W+13:14];
    end
    // product results
    if (state_r == pcrp_pkg::ST_MUL && mul_rsp.done) begin
      unique case (mop_r)
        pcrp_pkg::MOP_VDX: t_acc_r <= vd_term;
        pcrp_pkg::MOP_VDY, pcrp_pkg::MOP_VDZ: t_acc_r <= t_acc_r + vd_term;
        pcrp_pkg::MOP_DTX, pcrp_pkg::MOP_DTY, pcrp_pkg::MOP_DTZ: qmag_r <= q_mag;
        pcrp_pkg::MOP_QQX: perp_r <= pcrp_pkg::PERP_W'(mul_rsp.prod);
        pcrp_pkg::MOP_QQY, pcrp_pkg::MOP_QQZ: begin
          perp_r <= perp_r + pcrp_pkg::PERP_W'(mul_rsp.prod);
        end
        pcrp_pkg::MOP_TT:    tsq_r <= pcrp_pkg::TSQ_W'(mul_rsp.prod);
        pcrp_pkg::MOP_TW:    s_r <= SCORE_ONE + pcrp_pkg::S_W'(mul_rsp.prod);
        pcrp_pkg::MOP_SCORE: cand_r <= pcrp_pkg::SCORE_W'(mul_rsp.prod);
        pcrp_pkg::MOP_NX:    cand_r <= pcrp_pkg::SCORE_W'(mul_rsp.prod);
        pcrp_pkg::MOP_NY, pcrp_pkg::MOP_NZ: begin
          cand_r <= cand_r + pcrp_pkg::SCORE_W'(mul_rsp.prod);
        end
        pcrp_pkg::MOP_SQ: begin
          if (mul_rsp.prod <= 128'(sq_x_r)) sq_res_r <= sq_cand;
          sq_bit_r <= sq_bit_r - 6'd1;
        end
        default: ;
      endcase
    end
    // restoring divide, one quotient bit a cycle
    if (state_r == pcrp_pkg::ST_DCHK) begin
      rem_r     <= pcrp_pkg::REM_W'(perp16[pcrp_pkg::PERP_W-1:pcrp_pkg::TAN_W]);
      div_cnt_r <= 6'(pcrp_pkg::TAN_W - 1);
      tan2_r    <= '0;
    end
    if (state_r == pcrp_pkg::ST_DIV) begin
      if (div_r2 >= pcrp_pkg::REM_W'(tsq_r)) begin
        rem_r  <= div_r2 - pcrp_pkg::REM_W'(tsq_r);
        tan2_r <= {tan2_r[pcrp_pkg::TAN_W-2:0], 1'b1};
      end else begin
        rem_r  <= div_r2;
        tan2_r <= {tan2_r[pcrp_pkg::TAN_W-2:0], 1'b0};
      end
      div_cnt_r <= div_cnt_r - 6'd1;
    end
    // keep the best candidate, earliest wins ties
    if (state_r == pcrp_pkg::ST_CMP && better) begin
      found_r     <= 1'b1;
      best_val_r  <= cand_r;
      best_idx_r  <= scan_idx_r;
      best_tan2_r <= tan2_r;
    end
    // result beat
    if (state_r == pcrp_pkg::ST_DONE && state_nxt == pcrp_pkg::ST_IDLE) begin
      out_data_r.found      <= found_r;
      out_data_r.best_index <= found_r ? 10'(best_idx_r) : 10'd0;
      if (!found_r) out_data_r.measure <= '0;
      else if (|sq_res_r[pcrp_pkg::RES_W-1:32]) out_data_r.measure <= '1;
      else out_data_r.measure <= sq_res_r[31:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `PCRP_ASSERT_NOW(a_mul_done_owned, mul_rsp.done,
    (state_r == pcrp_pkg::ST_MUL && mul_pend_r), "product arrived outside a multiply wait")
  `PCRP_ASSERT_NOW(a_div_rem_bound, (state_r == pcrp_pkg::ST_DIV),
    (rem_r < pcrp_pkg::REM_W'(tsq_r)), "divider remainder not below divisor")
  `PCRP_ASSERT_NOW(a_best_in_range, (state_r == pcrp_pkg::ST_DONE && found_r),
    (best_idx_r < count_r), "winning slot beyond point count")
  `PCRP_ASSERT_NXT(a_clear_count,
    (state_r == pcrp_pkg::ST_IDLE && in_valid && in_data.func == pcrp_pkg::FUNC_CLEAR),
    (count_r == '0), "clear beat did not empty the store")

endmodule

// File: tb/sv/point_cloud_ray_pick_checker.sv
`timescale 1ns / 100ps

module point_cloud_ray_pick_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  pcrp_pkg::in_beat_t                in_data,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  pcrp_pkg::out_beat_t               out_data,
  input  logic                              cfg_we,
  input  logic [pcrp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pcrp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output int                                errors,
  output int                                pending
);
  import pcrp_pkg::*;

  localparam int     SLOTS    = 1024;
  localparam longint PICK_EPS = (64'd1 << 30) / 10000;

  logic signed [31:0] sx [SLOTS];
  logic signed [31:0] sy [SLOTS];
  logic signed [31:0] sz [SLOTS];
  int unsigned        count;
  logic [15:0]        max_tan;
  logic [23:0]        dist_wt;
  out_beat_t          answers [$];

  // floor square root of a wide value
  function automatic logic [63:0] root_of(logic [127:0] x);
    logic [63:0]  res;
    logic [127:0] c;
    res = '0;
    for (int b = 63; b >= 0; b--) begin
      c = 128'(res | (64'd1 << b));
      if (c * c <= x) res = c[63:0];
    end
    return res;
  endfunction

  function automatic logic [31:0] sat32(logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic [127:0] sq(longint v);
    logic [127:0] m;
    m = 128'(v < 0 ? -v : v);
    return m * m;
  endfunction

  // search over the stored points for one query beat
  function automatic out_beat_t search(in_beat_t b);
    out_beat_t    r;
    longint       vx, vy, vz, tt, t, dx, dy, dz;
    logic [127:0] perp, tsq, quo, score, bscore, d2;
    logic [63:0]  tan2, btan, lim;
    logic         hit;
    r = '0;
    hit = 0;
    bscore = '0;
    btan = '0;
    dx = longint'(b.dir_x);
    dy = longint'(b.dir_y);
    dz = longint'(b.dir_z);
    lim = (64'(max_tan) * 64'(max_tan)) << 16;
    for (int i = 0; i < int'(count); i++) begin
      vx = longint'(sx[i]) - longint'(b.pos_x);
      vy = longint'(sy[i]) - longint'(b.pos_y);
      vz = longint'(sz[i]) - longint'(b.pos_z);
      if (b.func == FUNC_PICK) begin
        tt = vx * dx + vy * dy + vz * dz;
        if (tt <= PICK_EPS) continue;
        t = tt >>> 14;
        if (t == 0) continue;
        perp = (sq(vx * 16384 - dx * t) + sq(vy * 16384 - dy * t)
                + sq(vz * 16384 - dz * t)) << 4;
        tsq = 128'(t) * 128'(t);
        quo = perp / tsq;
        tan2 = (quo[127:64] != 0) ? '1 : quo[63:0];
        if (tan2 >= lim) continue;
        score = 128'(tan2) * ((128'd1 << 32) + 128'(t) * 128'(dist_wt));
        if (!hit || score < bscore) begin
          hit = 1;
          bscore = score;
          btan = tan2;
          r.best_index = 10'(i);
        end
      end else begin
        d2 = sq(vx) + sq(vy) + sq(vz);
        if (!hit || d2 < bscore) begin
          hit = 1;
          bscore = d2;
          r.best_index = 10'(i);
        end
      end
    end
    if (hit) begin
      r.found = 1;
      r.measure = (b.func == FUNC_PICK) ? sat32(root_of(128'(btan))) : sat32(root_of(bscore));
    end
    return r;
  endfunction

  assign pending = answers.size();

  // track state, predict on accepted input beats, compare result beats
  always @(posedge clk) begin
    out_beat_t e;
    if (!rst_n) begin
      count <= 0;
      max_tan <= 16'd256;
      dist_wt <= '0;
      answers.delete();
      errors <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_MAX_TANGENT) max_tan <= cfg_wdata[15:0];
        else if (cfg_index == CFG_DIST_WEIGHT) dist_wt <= cfg_wdata;
      end
      if (out_valid && !out_stall) begin
        if (answers.size() == 0) begin
          $display("%t: result beat with nothing expected, actual %p", $time, out_data);
          errors <= errors + 1;
        end else begin
          e = answers.pop_front();
          if (e.found !== out_data.found || e.best_index !== out_data.best_index
              || e.measure !== out_data.measure) begin
            $display("%t: mismatch, expected found=%0d index=%0d measure=%h",
                     $time, e.found, e.best_index, e.measure);
            $display("%t:           actual found=%0d index=%0d measure=%h",
                     $time, out_data.found, out_data.best_index, out_data.measure);
            errors <= errors + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        case (in_data.func)
          FUNC_LOAD: begin
            sx[in_data.point_index] = in_data.pos_x;
            sy[in_data.point_index] = in_data.pos_y;
            sz[in_data.point_index] = in_data.pos_z;
            if (in_data.last_point) count <= in_data.point_index + 1;
          end
          FUNC_CLEAR: count <= 0;
          default: answers.push_back(search(in_data));
        endcase
      end
    end
  end

endmodule

// File: tb/sv/point_cloud_ray_pick_tb.sv
`timescale 1ns / 100ps

module point_cloud_ray_pick_tb;
  import pcrp_pkg::*;

  localparam int NEAR_SLOTS = 12;

  logic                  clk = 0;
  logic                  rst_n = 0;
  logic                  in_valid = 0;
  logic                  in_stall;
  in_beat_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1;
  out_beat_t             out_data;
  logic                  cfg_we = 0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  int                    errors;
  int                    pending;

  int          queries_sent = 0;
  int          results_seen = 0;
  int          beats_sent = 0;
  int          idle_max = 8;
  int unsigned cnt = 0;
  bit          written [1024];
  logic signed [31:0] kx [1024];
  logic signed [31:0] ky [1024];
  logic signed [31:0] kz [1024];

  point_cloud_ray_pick DUT (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_we, .cfg_index, .cfg_wdata
  );

  point_cloud_ray_pick_checker u_checker (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_we, .cfg_index, .cfg_wdata, .errors, .pending
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // result side: random stall before each beat
  initial begin
    int  w;
    bit  acc;
    forever begin
      w = $urandom_range(0, idle_max);
      if (w > 0) begin
        out_stall <= 1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 0;
      do begin
        @(negedge clk) acc = out_valid;
        @(posedge clk);
      end while (!acc);
      results_seen++;
    end
  end

  function automatic in_beat_t mk(logic [1:0] f, int idx, bit last, longint x, longint y,
                                  longint z, int dx, int dy, int dz);
    in_beat_t b;
    b.func = f;
    b.point_index = 10'(idx);
    b.last_point = last;
    b.pos_x = 32'(x);
    b.pos_y = 32'(y);
    b.pos_z = 32'(z);
    b.dir_x = 16'(dx);
    b.dir_y = 16'(dy);
    b.dir_z = 16'(dz);
    return b;
  endfunction

  // one input beat with a random gap ahead of it
  task automatic send(in_beat_t b);
    int gap;
    bit st;
    gap = $urandom_range(0, idle_max);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= b;
    do begin
      @(negedge clk) st = in_stall;
      @(posedge clk);
    end while (st);
    beats_sent++;
    if (b.func == FUNC_PICK || b.func == FUNC_NEAR) queries_sent++;
    if (b.func == FUNC_LOAD) begin
      written[b.point_index] = 1;
      kx[b.point_index] = b.pos_x;
      ky[b.point_index] = b.pos_y;
      kz[b.point_index] = b.pos_z;
      if (b.last_point) cnt = b.point_index + 1;
    end else if (b.func == FUNC_CLEAR) begin
      cnt = 0;
    end
  endtask

  // register write once every result is back
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    in_valid <= 0;
    while (results_seen != queries_sent) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  function automatic longint coord();
    return ($urandom_range(0, 99) < 85) ? longint'($urandom_range(0, 2 << 20)) - (1 << 20)
                                        : longint'(int'($urandom));
  endfunction

  function automatic bit below_written(int idx);
    for (int i = 0; i < idx; i++) if (!written[i]) return 0;
    return 1;
  endfunction

  // random beat: mostly queries, many picks aimed at stored points, some loads, clears and noise
  task automatic random_beat();
    int     r, idx, dx, dy, dz, tgt;
    longint d, ox, oy, oz;
    r = $urandom_range(0, 99);
    if (r < 22) begin
      idx = $urandom_range(0, NEAR_SLOTS - 1);
      send(mk(FUNC_LOAD, idx, below_written(idx) && $urandom_range(0, 2) == 0,
              coord(), coord(), coord(), $urandom, $urandom, $urandom));
    end else if (r < 26) begin
      idx = $urandom_range(0, 1023);
      send(mk(FUNC_LOAD, idx, idx < NEAR_SLOTS && below_written(idx),
              coord(), coord(), coord(), $urandom, $urandom, $urandom));
    end else if (r < 30) begin
      send(mk(FUNC_CLEAR, $urandom, $urandom, coord(), coord(), coord(),
              $urandom, $urandom, $urandom));
    end else if (r < 55) begin
      send(mk(FUNC_NEAR, $urandom, $urandom, coord(), coord(), coord(),
              $urandom, $urandom, $urandom));
    end else if (r < 90 && cnt > 0) begin
      case ($urandom_range(0, 3))
        0: begin dx = 16384; dy = 0; dz = 0; end
        1: begin dx = 0; dy = -16384; dz = 0; end
        2: begin dx = 0; dy = 0; dz = 16384; end
        default: begin
          dx = int'($urandom_range(0, 22000)) - 11000;
          dy = int'($urandom_range(0, 22000)) - 11000;
          dz = int'($urandom_range(0, 22000)) - 11000;
        end
      endcase
      tgt = $urandom_range(0, cnt - 1);
      d = $urandom_range(1, 1 << 18);
      ox = longint'(kx[tgt]) - ((d * dx) >>> 14) + $urandom_range(0, 4000) - 2000;
      oy = longint'(ky[tgt]) - ((d * dy) >>> 14) + $urandom_range(0, 4000) - 2000;
      oz = longint'(kz[tgt]) - ((d * dz) >>> 14) + $urandom_range(0, 4000) - 2000;
      send(mk(FUNC_PICK, $urandom, $urandom, ox, oy, oz, dx, dy, dz));
    end else begin
      send(mk(FUNC_PICK, $urandom, $urandom, coord(), coord(), coord(),
              $urandom, $urandom, $urandom));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: empty store, extreme coordinates and directions, clear
    write_reg(CFG_MAX_TANGENT, 24'd256);
    write_reg(CFG_DIST_WEIGHT, 24'd0);
    send(mk(FUNC_PICK, 0, 0, 0, 0, 0, 16384, 0, 0));
    send(mk(FUNC_NEAR, 1023, 1, 0, 0, 0, 0, 0, 0));
    send(mk(FUNC_LOAD, 0, 0, 0, 0, 0, 0, 0, 0));
    send(mk(FUNC_LOAD, 1, 0, 1 << 20, 0, 0, -1, -1, -1));
    send(mk(FUNC_LOAD, 2, 0, -(64'd1 << 31), -(64'd1 << 31), -(64'd1 << 31), 0, 0, 0));
    send(mk(FUNC_LOAD, 3, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0));
    send(mk(FUNC_PICK, 0, 0, -(1 << 16), 0, 0, 16384, 0, 0));
    send(mk(FUNC_PICK, 0, 0, 2 << 20, 100, -100, -16384, 0, 0));
    send(mk(FUNC_PICK, 0, 0, 0, 0, 0, -32768, -32768, -32768));
    send(mk(FUNC_PICK, 0, 0, 5, -5, 5, 32767, 32767, 32767));
    send(mk(FUNC_PICK, 0, 0, 0, 0, 0, 0, 16384, 0));
    send(mk(FUNC_NEAR, 0, 0, 0, 0, 0, 0, 0, 0));
    send(mk(FUNC_NEAR, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0));
    send(mk(FUNC_NEAR, 0, 0, -(64'd1 << 31), 0, 32'h7FFF_FFFF, 0, 0, 0));
    send(mk(FUNC_LOAD, 1023, 0, 7, 7, 7, 0, 0, 0));
    send(mk(FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
    send(mk(FUNC_PICK, 0, 0, -(1 << 16), 0, 0, 16384, 0, 0));
    send(mk(FUNC_NEAR, 0, 0, 0, 0, 0, 0, 0, 0));
    send(mk(FUNC_LOAD, 0, 1, 1 << 16, 1 << 16, 1 << 16, 0, 0, 0));
    send(mk(FUNC_NEAR, 0, 0, 0, 0, 0, 0, 0, 0));

    // random phases over several register settings
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin write_reg(CFG_MAX_TANGENT, 24'd65535); write_reg(CFG_DIST_WEIGHT, 24'd0); end
        1: begin write_reg(CFG_MAX_TANGENT, 24'd0); write_reg(CFG_DIST_WEIGHT, 24'hFFFFFF); end
        2: begin write_reg(CFG_MAX_TANGENT, 24'd65535); write_reg(CFG_DIST_WEIGHT, 24'hFFFFFF); end
        default: begin
          write_reg(CFG_MAX_TANGENT, 24'($urandom_range(1, 4096)));
          write_reg(CFG_DIST_WEIGHT, 24'($urandom));
        end
      endcase
      idle_max = (ph % 3 == 1) ? 0 : 8;
      repeat (56) random_beat();
    end

    in_valid <= 0;
    while (results_seen != queries_sent) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("covered %0d input beats, %0d queries checked, 10 register settings",
             beats_sent, results_seen);
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #80ms;
    $display("simulation failed");
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/pcrp_pkg.sv
sv/pcrp_ram.sv
sv/pcrp_mul.sv
sv/point_cloud_ray_pick.sv
tb/sv/point_cloud_ray_pick_checker.sv
tb/sv/point_cloud_ray_pick_tb.sv
